>>> sv/aes128_cmac_engine_macros.svh
// Assertion macros for the AES-128 CMAC engine checker.
// Included by the checker file only.
`ifndef AES128_CMAC_ENGINE_MACROS_SVH
`define AES128_CMAC_ENGINE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CMAC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication also checked while reset is high.
`define CMAC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> sv/cmac_pkg.sv
// Package for the AES-128 CMAC engine: S-box, round constants, round helpers and the
// payload types of the channels. No dependencies.
package cmac_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned BlockW = 128;
  localparam int unsigned CountW = 5;
  localparam int unsigned IdxW   = 1;
  localparam int unsigned Rounds = 10;

  localparam logic [IdxW-1:0] RegKeyHi = 1'b0;
  localparam logic [IdxW-1:0] RegKeyLo = 1'b1;

  localparam logic [7:0] RbConst  = 8'h87;
  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [7:0] PolyByte = 8'h1b;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [HalfW-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [HalfW-1:0]  msg_hi;
    logic [HalfW-1:0]  msg_lo;
    logic [CountW-1:0] valid_bytes;
    logic              is_last;
  } msg_t;

  typedef struct packed {
    logic [HalfW-1:0] tag_hi;
    logic [HalfW-1:0] tag_lo;
  } tag_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = PolyByte;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? PolyByte : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] byte_at(input logic [BlockW-1:0] b, input int i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  // GF(2^128) doubling for subkeys
  function automatic logic [BlockW-1:0] dbl(input logic [BlockW-1:0] b);
    logic [BlockW-1:0] v;
    v = {b[BlockW-2:0], 1'b0};
    if (b[BlockW-1]) v[7:0] = v[7:0] ^ RbConst;
    return v;
  endfunction

endpackage

>>> sv/cmac_if.sv
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing.
interface cmac_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/cmac_round.sv
// One AES-128 round step: state and round-key update, shared over all rounds.
// Depends on cmac_pkg.
module cmac_round (
  input  logic [cmac_pkg::BlockW-1:0] state_in,
  input  logic [cmac_pkg::BlockW-1:0] rkey_in,
  input  logic [3:0]                  round,
  output logic [cmac_pkg::BlockW-1:0] state_out,
  output logic [cmac_pkg::BlockW-1:0] rkey_out
);
  import cmac_pkg::*;

  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [31:0] w0, w1, w2, w3, sw;

  always_comb begin
    w3 = rkey_in[31:0];
    sw = {sbox(w3[23:16]) ^ rcon(round), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = rkey_in[127:96] ^ sw;
    w1 = rkey_in[95:64] ^ w0;
    w2 = rkey_in[63:32] ^ w1;
    rkey_out = {w0, w1, w2, w2 ^ w3};
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = sbox(byte_at(state_in, ((c + i) % 4) * 4 + i));
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        m[c*4+i] = t[c*4+i] ^ t[c*4+0] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3]
                 ^ xtime(t[c*4+i] ^ t[c*4+((i + 1) % 4)]);
      end
    end
    for (int k = 0; k < 16; k++) begin
      state_out[BlockW-1-8*k -: 8] = ((round == 4'(Rounds)) ? t[k] : m[k])
                                     ^ rkey_out[BlockW-1-8*k -: 8];
    end
  end
endmodule

>>> sv/aes128_cmac_engine.sv
// AES-128 CMAC engine: one 16-byte block per transfer on msg, the tag leaves on tag after the
// block marked last and the chaining value then restarts from zero. The key is written in two
// halves on cfg between blocks; a write makes the next block derive K1 and K2 again and keeps
// the chaining value. A single shared round unit does one AES round per cycle; a block passes
// through the initial key addition on the transfer, 10 rounds in Run and a store in Done before
// the next block can be taken. The first block after reset or a key write first encrypts zero
// for the subkeys, then its own block. A tag not yet taken holds off the next block, and a
// pending key write goes before a block.
module aes128_cmac_engine (
  input logic clk,
  input logic rst,
  cmac_if.sink   cfg,
  cmac_if.sink   msg,
  cmac_if.source tag
);
  import cmac_pkg::*;

  typedef enum logic [1:0] {Idle, Run, Done} state_t;

  state_t             state;
  logic               sub_phase;
  logic [3:0]         round;
  logic [BlockW-1:0]  key, st, rk, chain, k1, k2, blk;
  logic               subkeys_ready, last;
  logic [CountW-1:0]  count;
  logic [BlockW-1:0]  st_next, rk_next, padded, l_dbl, l_dbl2;
  logic [BlockW-1:0]  src_blk, src_k1, src_k2;
  logic [CountW-1:0]  src_count;
  logic               src_last;
  logic               out_valid;
  logic [BlockW-1:0]  out_tag;

  cmac_round u_round (.state_in(st), .rkey_in(rk), .round(round),
                      .state_out(st_next), .rkey_out(rk_next));

  assign cfg.ready = (state == Idle);
  assign msg.ready = (state == Idle) && !out_valid && !cfg.valid;
  assign tag.valid = out_valid;
  assign tag.data.tag_hi = out_tag[BlockW-1:HalfW];
  assign tag.data.tag_lo = out_tag[HalfW-1:0];

  // block prepared from the transfer in Idle, from the held block after derivation
  always_comb begin
    src_blk   = (state == Idle) ? {msg.data.msg_hi, msg.data.msg_lo} : blk;
    src_count = (state == Idle) ? msg.data.valid_bytes : count;
    src_last  = (state == Idle) ? msg.data.is_last : last;
    l_dbl     = dbl(st);
    l_dbl2    = dbl(l_dbl);
    src_k1    = sub_phase ? l_dbl : k1;
    src_k2    = sub_phase ? l_dbl2 : k2;
    padded    = src_blk;
    if (src_last) begin
      if (src_count[CountW-1]) begin
        padded = src_blk ^ src_k1;
      end else begin
        for (int i = 0; i < 16; i++) begin
          if (i > int'(src_count)) padded[BlockW-1-8*i -: 8] = 8'h00;
          if (i == int'(src_count)) padded[BlockW-1-8*i -: 8] = PadByte;
        end
        padded = padded ^ src_k2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle; out_valid <= 1'b0; subkeys_ready <= 1'b0;
      key <= '0; chain <= '0; k1 <= '0; k2 <= '0; round <= '0; sub_phase <= 1'b0;
    end else begin
      if (tag.valid && tag.ready) out_valid <= 1'b0;
      case (state)
        Idle: begin
          if (cfg.valid && cfg.ready) begin
            case (cfg.data.idx)
              RegKeyHi: key[BlockW-1:HalfW] <= cfg.data.wdata;
              RegKeyLo: key[HalfW-1:0] <= cfg.data.wdata;
              default: ;
            endcase
            subkeys_ready <= 1'b0;
          end
          if (msg.valid && msg.ready) begin
            blk       <= src_blk;
            count     <= src_count;
            last      <= src_last;
            rk        <= key;
            round     <= 4'd1;
            sub_phase <= !subkeys_ready;
            st        <= subkeys_ready ? (chain ^ padded ^ key) : key;
            state     <= Run;
          end
        end
        Run: begin
          st <= st_next; rk <= rk_next;
          if (round == 4'(Rounds)) state <= Done;
          else round <= round + 4'd1;
        end
        Done: begin
          if (sub_phase) begin
            k1 <= l_dbl; k2 <= l_dbl2; subkeys_ready <= 1'b1;
            sub_phase <= 1'b0;
            rk <= key; round <= 4'd1;
            st <= chain ^ padded ^ key;
            state <= Run;
          end else begin
            if (last) begin
              out_tag <= st; out_valid <= 1'b1; chain <= '0;
            end else begin
              chain <= st;
            end
            state <= Idle;
          end
        end
        default: state <= Idle;
      endcase
    end
  end
endmodule

>>> sv/cmac_checker.sv
// Port-level checker for the AES-128 CMAC engine, bound into aes128_cmac_engine.
// Depends on aes128_cmac_engine_macros.svh.
`include "aes128_cmac_engine_macros.svh"
module cmac_checker (
  input logic clk,
  input logic rst,
  input logic msg_valid,
  input logic msg_ready,
  input logic tag_valid,
  input logic tag_ready,
  input logic cfg_ready
);
  `CMAC_ASSERT(a_busy_after_take, clk, rst, (msg_valid && msg_ready) |=> !msg_ready, "accepted twice")
  `CMAC_ASSERT(a_tag_holds, clk, rst, (tag_valid && !tag_ready) |=> tag_valid, "tag dropped")
  `CMAC_ASSERT(a_cfg_busy, clk, rst, (msg_valid && msg_ready) |=> !cfg_ready, "cfg while busy")
  `CMAC_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !tag_valid, "tag after reset")
endmodule

bind aes128_cmac_engine cmac_checker u_cmac_checker (
  .clk(clk), .rst(rst), .msg_valid(msg.valid), .msg_ready(msg.ready),
  .tag_valid(tag.valid), .tag_ready(tag.ready), .cfg_ready(cfg.ready));

>>> test/tb.sv
// Testbench for aes128_cmac_engine: streams messages block by block, predicts each CMAC tag
// with its own AES-128 model and compares every transferred tag against it.
// Depends on cmac_pkg, cmac_if and the engine RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmac_pkg::*;

  class cmac_scoreboard;
    bit [HalfW-1:0]  key_hi, key_lo;
    bit [BlockW-1:0] chain, k1, k2;
    bit              subkeys_ok;
    bit [BlockW-1:0] tags_due[$];
    int              errors;

    static function bit [7:0] xt(bit [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? PolyByte : 8'h00);
    endfunction

    static function bit [BlockW-1:0] aes_encrypt(bit [BlockW-1:0] key, bit [BlockW-1:0] pt);
      bit [7:0] rc[10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                           8'h1b, 8'h36};
      bit [7:0] rk[176];
      bit [7:0] s[16];
      bit [7:0] t[16];
      bit [7:0] w[4];
      bit [7:0] a0, a1, a2, a3, all, first;
      bit [BlockW-1:0] ct;
      for (int i = 0; i < 16; i++) begin
        rk[i] = key[BlockW-1-8*i -: 8];
        s[i]  = pt[BlockW-1-8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) w[j] = rk[(i-1)*4+j];
        if (i % 4 == 0) begin
          first = w[0];
          w[0] = sbox(w[1]) ^ rc[i/4-1];
          w[1] = sbox(w[2]);
          w[2] = sbox(w[3]);
          w[3] = sbox(first);
        end
        for (int j = 0; j < 4; j++) rk[i*4+j] = rk[(i-4)*4+j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int r = 1; r <= Rounds; r++) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) t[c*4+i] = sbox(s[((c+i)%4)*4+i]);
        if (r != Rounds) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[c*4]   = a0 ^ all ^ xt(a0 ^ a1);
            t[c*4+1] = a1 ^ all ^ xt(a1 ^ a2);
            t[c*4+2] = a2 ^ all ^ xt(a2 ^ a3);
            t[c*4+3] = a3 ^ all ^ xt(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r*16+i];
      end
      for (int i = 0; i < 16; i++) ct[BlockW-1-8*i -: 8] = s[i];
      return ct;
    endfunction

    static function bit [BlockW-1:0] gf_double(bit [BlockW-1:0] b);
      bit [BlockW-1:0] v;
      v = {b[BlockW-2:0], 1'b0};
      if (b[BlockW-1]) v[7:0] ^= RbConst;
      return v;
    endfunction

    function void write_reg(bit [IdxW-1:0] idx, bit [HalfW-1:0] v);
      if (idx == RegKeyHi) key_hi = v;
      else key_lo = v;
      subkeys_ok = 0;
    endfunction

    function void note_block(msg_t m);
      bit [BlockW-1:0] key, blk, st;
      int n;
      key = {key_hi, key_lo};
      if (!subkeys_ok) begin
        k1 = gf_double(aes_encrypt(key, '0));
        k2 = gf_double(k1);
        subkeys_ok = 1;
      end
      blk = {m.msg_hi, m.msg_lo};
      if (m.is_last) begin
        n = m.valid_bytes;
        if (n >= 16) blk ^= k1;
        else begin
          for (int i = n; i < 16; i++) blk[BlockW-1-8*i -: 8] = 8'h00;
          blk[BlockW-1-8*n -: 8] = PadByte;
          blk ^= k2;
        end
      end
      st = aes_encrypt(key, chain ^ blk);
      if (m.is_last) begin
        tags_due.push_back(st);
        chain = '0;
      end else chain = st;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_tag(tag_t t);
      bit [BlockW-1:0] want;
      if (tags_due.size() == 0) begin
        report($sformatf("unexpected tag %h%h", t.tag_hi, t.tag_lo));
        return;
      end
      want = tags_due.pop_front();
      if (t.tag_hi !== want[BlockW-1:HalfW])
        report($sformatf("tag_hi %h, want %h", t.tag_hi, want[BlockW-1:HalfW]));
      if (t.tag_lo !== want[HalfW-1:0])
        report($sformatf("tag_lo %h, want %h", t.tag_lo, want[HalfW-1:0]));
    endtask
  endclass

  logic clk;
  logic rst;

  cmac_if #(.payload_t(cfg_t)) cfg_ch ();
  cmac_if #(.payload_t(msg_t)) msg_ch ();
  cmac_if #(.payload_t(tag_t)) tag_ch ();

  aes128_cmac_engine u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch.sink),
    .msg (msg_ch.sink),
    .tag (tag_ch.source)
  );

  cmac_scoreboard sb = new();
  bit steady;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tag sink: random back-pressure, plus long holds on request
  initial begin
    int gap;
    gap = 0;
    tag_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tag_ch.valid && tag_ch.ready) sb.check_tag(tag_ch.data);
      if (hold_cycles > 0) begin
        hold_cycles--;
        tag_ch.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        tag_ch.ready <= 1'b0;
      end else begin
        tag_ch.ready <= 1'b1;
        gap = pick_gap();
      end
    end
  end

  task send_block(bit [HalfW-1:0] hi, bit [HalfW-1:0] lo, bit [CountW-1:0] vb, bit last);
    msg_t m;
    int gap;
    m = '{msg_hi: hi, msg_lo: lo, valid_bytes: vb, is_last: last};
    gap = pick_gap();
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.data  <= m;
    do @(posedge clk); while (!msg_ch.ready);
    sb.note_block(m);
  endtask

  task drain();
    msg_ch.valid <= 1'b0;
    while (sb.tags_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_key(bit [IdxW-1:0] idx, bit [HalfW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{idx: idx, wdata: v};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  function automatic bit [HalfW-1:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task random_message();
    int nblk;
    nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    for (int b = 1; b < nblk; b++)
      send_block(rnd64(), rnd64(), CountW'($urandom_range(0, 31)), 1'b0);
    send_block(rnd64(), rnd64(), CountW'($urandom_range(0, 16)), 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    msg_ch.valid <= 1'b0;
    msg_ch.data  <= '0;
    steady = 0;
    hold_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key: empty message, full blocks, odd padding lengths
    send_block('0, '0, 5'd0, 1'b1);
    send_block('1, '1, 5'd16, 1'b1);
    send_block('1, '1, 5'd0, 1'b1);
    for (int n = 1; n < 16; n += 2) send_block(rnd64(), rnd64(), CountW'(n), 1'b1);
    // count above a full block on the last block
    send_block(rnd64(), rnd64(), 5'd27, 1'b1);
    send_block('1, '0, 5'd31, 1'b0);
    send_block('0, '1, 5'd15, 1'b1);
    drain();

    write_key(RegKeyHi, 64'h2b7e151628aed2a6);
    write_key(RegKeyLo, 64'habf7158809cf4f3c);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    send_block('0, '0, 5'd0, 1'b1);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd0, 1'b0);
    send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd0, 1'b0);
    drain();
    // key change in the middle of a message keeps the chain
    write_key(RegKeyLo, '1);
    send_block(rnd64(), rnd64(), 5'd7, 1'b1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_key(RegKeyHi, '1); write_key(RegKeyLo, '1); end
        1: begin write_key(RegKeyHi, '0); write_key(RegKeyLo, '0); end
        default: begin write_key(RegKeyHi, rnd64()); write_key(RegKeyLo, rnd64()); end
      endcase
      steady = (phase == 3);
      for (int k = 0; k < 40; k++) begin
        if (k == 20 && phase == 2) hold_cycles = 400;
        random_message();
      end
      if (phase == 4) begin
        // key change between blocks of one message
        send_block(rnd64(), rnd64(), 5'd3, 1'b0);
        drain();
        write_key(RegKeyHi, rnd64());
        send_block(rnd64(), rnd64(), 5'd9, 1'b1);
      end
      drain();
    end
    steady = 0;

    while (sb.tags_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/cmac_pkg.sv
sv/cmac_if.sv
sv/cmac_round.sv
sv/aes128_cmac_engine.sv
sv/cmac_checker.sv
test/tb.sv
